// ===== hw/rtl/sfc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the serial I/O frame checker
// Holds the start mark, the byte mask and the status codes of a result item.
// ---------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] START_MARK = 8'hE0;
  localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BADSOM  = 2'd1,
    ST_BADSUM  = 2'd2,
    ST_ZEROLEN = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/sfc_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_in_if: byte channel into the frame checker
// Carries one raw frame byte and its start-of-frame flag per item.
// ---------------------------------------------------------------------------
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ===== hw/rtl/sfc_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_out_if: result channel out of the frame checker
// Carries the status, payload length and packet code of one checked frame.
// ---------------------------------------------------------------------------
interface sfc_out_if;
  logic             valid;
  logic             ready;
  sfc_pkg::status_t status;
  logic [7:0]       payload_length;
  logic [7:0]       packet_code;

  modport source (output valid, output status, output payload_length,
                  output packet_code, input ready);
  modport sink   (input valid, input status, input payload_length,
                  input packet_code, output ready);
endinterface

// ===== hw/rtl/serial_io_frame_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_io_frame_checker: frame parser and 8-bit sum check for a serial link
//
// Bytes enter on the frames channel, one item per byte, with frame_start set
// on the first byte of each frame. A frame is a 0xE0 start mark, an address,
// a length byte (data bytes plus one), the data bytes and a wrapping 8-bit
// sum of address, length and data. One result item leaves on the results
// channel at the checksum byte, or at once for a bad start mark or a zero
// length byte. Bytes outside a frame give no result.
//
// An accepted byte is captured in an input register, parsed there against
// the frame state and, if it gives a result, lands in the result register,
// which offers it. One byte is accepted every cycle unless a byte waits on
// the stalled result register; the running sum and byte count update per byte.
// When the receiver stalls, a waiting result holds, and the input register
// still drains bytes that give no result; ready falls only when a byte in
// the input register would need the occupied result register.
// Synchronous reset empties both registers and returns the parser to idle.
// ---------------------------------------------------------------------------
module serial_io_frame_checker (
  input  logic      clk,
  input  logic      rst,
  sfc_in_if.sink    frames,
  sfc_out_if.source results
);
  import sfc_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_ADDR = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_SUM  = 5'b10000
  } phase_t;

  // Input register.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_start;

  // Frame state.
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] saved_length, saved_length_next;
  logic [BYTE_W-1:0] saved_code, saved_code_next;

  // Result register.
  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_length;
  logic [BYTE_W-1:0] out_code;

  logic              has_result;
  status_t           res_status;
  logic [BYTE_W-1:0] res_length;
  logic [BYTE_W-1:0] res_code;

  logic out_free;
  logic stage_go;
  logic [BYTE_W-1:0] left_dec;

  assign out_free = !out_valid || results.ready;
  // A byte that gives no result may pass even while the result is stalled.
  assign stage_go = in_valid && (out_free || !has_result);
  assign frames.ready = !in_valid || stage_go;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    saved_length_next = saved_length;
    saved_code_next   = saved_code;
    has_result        = 1'b0;
    res_status        = ST_GOOD;
    res_length        = '0;
    res_code          = '0;

    if (in_start) begin
      running_sum_next  = '0;
      bytes_left_next   = '0;
      saved_length_next = '0;
      saved_code_next   = '0;
      if (in_byte != START_MARK) begin
        phase_next = PH_IDLE;
        has_result = 1'b1;
        res_status = ST_BADSOM;
      end else begin
        phase_next = PH_ADDR;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_ADDR: begin
          running_sum_next = (running_sum + in_byte) & BYTE_MASK;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          if (in_byte == '0) begin
            phase_next = PH_IDLE;
            has_result = 1'b1;
            res_status = ST_ZEROLEN;
          end else begin
            running_sum_next  = (running_sum + in_byte) & BYTE_MASK;
            saved_length_next = in_byte - 8'd1;
            bytes_left_next   = in_byte - 8'd1;
            saved_code_next   = '0;
            phase_next        = (in_byte == 8'd1) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          // The first data byte is the one seen while no byte has been counted off.
          if (bytes_left == saved_length) begin
            saved_code_next = in_byte;
          end
          running_sum_next = (running_sum + in_byte) & BYTE_MASK;
          bytes_left_next  = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_next = PH_IDLE;
          has_result = 1'b1;
          res_code   = saved_code;
          if (in_byte == running_sum) begin
            res_status = ST_GOOD;
            res_length = saved_length;
          end else begin
            res_status = ST_BADSUM;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frames.valid && frames.ready) begin
      in_valid <= 1'b1;
    end else if (stage_go) begin
      in_valid <= 1'b0;
    end
    if (frames.valid && frames.ready) begin
      in_byte  <= frames.frame_byte;
      in_start <= frames.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bytes_left   <= '0;
      running_sum  <= '0;
      saved_length <= '0;
      saved_code   <= '0;
    end else if (stage_go) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      running_sum  <= running_sum_next;
      saved_length <= saved_length_next;
      saved_code   <= saved_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && has_result) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (stage_go && has_result) begin
      out_status <= res_status;
      out_length <= res_length;
      out_code   <= res_code;
    end
  end

  assign results.valid          = out_valid;
  assign results.status         = out_status;
  assign results.payload_length = out_length;
  assign results.packet_code    = out_code;

  a_early_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_BADSOM || out_status == ST_ZEROLEN)
      |-> out_length == '0 && out_code == '0)
    else $error("start or length error result carries nonzero fields");

  a_badsum_length_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_BADSUM |-> out_length == '0)
    else $error("checksum mismatch result carries a payload length");

  a_result_ends_frame: assert property (@(posedge clk) disable iff (rst)
    stage_go && has_result |=> phase == PH_IDLE)
    else $error("parser did not return to idle after a result");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && has_result && out_valid && !results.ready |=> in_valid)
    else $error("input item dropped while the result register was stalled");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the serial I/O frame checker
// Feeds directed and random byte streams (good frames, bad checksums, bad
// start marks, zero lengths, cut-off frames and stray bytes) through the byte
// channel with random gaps on both sides, predicts each result from its own
// frame parser and compares every result item field by field.
// ---------------------------------------------------------------------------
module tb_top;
  import sfc_pkg::*;

  localparam int unsigned STIM_BYTES   = 1900;
  localparam int unsigned GAP_PERCENT  = 34;
  localparam int unsigned HANG_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned STEADY_FIRST = 700;
  localparam int unsigned STEADY_LAST  = 1000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } parse_phase_t;

  typedef struct {
    logic [7:0] value;
    logic       start;
  } frame_byte_t;

  typedef struct {
    status_t    status;
    logic [7:0] payload_length;
    logic [7:0] packet_code;
  } frame_result_t;

  logic clk;
  logic rst;

  sfc_in_if  frames ();
  sfc_out_if results ();

  serial_io_frame_checker dut (
    .clk     (clk),
    .rst     (rst),
    .frames  (frames),
    .results (results)
  );

  frame_byte_t   byte_queue[$];
  frame_result_t expected_results[$];

  int unsigned bytes_accepted;
  int unsigned idle_cycles;
  int unsigned fail_count;
  bit          steady;

  // Parser state of the predictor.
  parse_phase_t parse_phase;
  logic [7:0]   bytes_left;
  logic [7:0]   running_sum;
  logic [7:0]   saved_length;
  logic [7:0]   saved_code;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  assign steady = (bytes_accepted >= STEADY_FIRST) && (bytes_accepted < STEADY_LAST);

  // Returns 1 when the byte completes a result, which is left in res.
  function automatic bit parse_frame_byte(input logic [7:0] b, input logic s,
                                          output frame_result_t res);
    res.status         = ST_GOOD;
    res.payload_length = 8'd0;
    res.packet_code    = 8'd0;
    if (s) begin
      running_sum  = 8'd0;
      bytes_left   = 8'd0;
      saved_length = 8'd0;
      saved_code   = 8'd0;
      if (b != START_MARK) begin
        parse_phase = PH_IDLE;
        res.status  = ST_BADSOM;
        return 1'b1;
      end
      parse_phase = PH_ADDR;
      return 1'b0;
    end
    case (parse_phase)
      PH_ADDR: begin
        running_sum = running_sum + b;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          parse_phase = PH_IDLE;
          res.status  = ST_ZEROLEN;
          return 1'b1;
        end
        running_sum  = running_sum + b;
        saved_length = b - 8'd1;
        bytes_left   = saved_length;
        saved_code   = 8'd0;
        parse_phase  = (bytes_left == 8'd0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        if (bytes_left == saved_length) saved_code = b;
        running_sum = running_sum + b;
        bytes_left  = bytes_left - 8'd1;
        if (bytes_left == 8'd0) parse_phase = PH_SUM;
      end
      PH_SUM: begin
        parse_phase     = PH_IDLE;
        res.packet_code = saved_code;
        if (b == running_sum) begin
          res.payload_length = saved_length;
        end else begin
          res.status = ST_BADSUM;
        end
        return 1'b1;
      end
      default: begin
        parse_phase = PH_IDLE;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic start);
    frame_byte_t item;
    item.value = value;
    item.start = start;
    byte_queue.push_back(item);
  endtask

  // Queues a frame with random data bytes. A negative cut sends it whole,
  // otherwise only its first cut bytes go out.
  task automatic add_frame(input logic [7:0] addr, input logic [7:0] len_byte,
                           input bit sum_ok, input int cut);
    logic [7:0] seq[$];
    logic [7:0] sum;
    logic [7:0] data;
    seq.push_back(START_MARK);
    seq.push_back(addr);
    seq.push_back(len_byte);
    if (len_byte != 8'd0) begin
      sum = addr + len_byte;
      for (int i = 1; i < int'(len_byte); i++) begin
        data = 8'($urandom_range(0, 255));
        seq.push_back(data);
        sum = sum + data;
      end
      if (!sum_ok) sum = sum ^ 8'($urandom_range(1, 255));
      seq.push_back(sum);
    end
    for (int i = 0; i < seq.size() && (cut < 0 || i < cut); i++) begin
      push_byte(seq[i], i == 0);
    end
  endtask

  // Byte driver: a new item goes out when the channel is empty or the
  // current item is taken.
  always @(posedge clk) begin : drive_bytes
    frame_byte_t item;
    if (rst) begin
      frames.valid       <= 1'b0;
      frames.frame_byte  <= 8'd0;
      frames.frame_start <= 1'b0;
    end else if (!frames.valid || frames.ready) begin
      if (byte_queue.size() != 0 &&
          (steady || $urandom_range(0, 99) >= GAP_PERCENT)) begin
        item = byte_queue.pop_front();
        frames.valid       <= 1'b1;
        frames.frame_byte  <= item.value;
        frames.frame_start <= item.start;
      end else begin
        frames.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= steady || ($urandom_range(0, 99) >= GAP_PERCENT);
    end
  end

  // Result check first, then prediction for the byte taken at this edge.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    frame_result_t got;
    if (rst) begin
      parse_phase    = PH_IDLE;
      bytes_left     = 8'd0;
      running_sum    = 8'd0;
      saved_length   = 8'd0;
      saved_code     = 8'd0;
      idle_cycles    = 0;
      fail_count     = 0;
      bytes_accepted <= 0;
    end else begin
      if (results.valid && results.ready) begin
        got.status         = results.status;
        got.payload_length = results.payload_length;
        got.packet_code    = results.packet_code;
        if (expected_results.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("unexpected result: status %0d length %0d code 0x%02h",
                     got.status, got.payload_length, got.packet_code);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.payload_length !== want.payload_length ||
              got.packet_code !== want.packet_code) begin
            if (fail_count < MAX_REPORTS)
              $display({"mismatch: expected status %0d length %0d code 0x%02h,",
                        " got status %0d length %0d code 0x%02h"},
                       want.status, want.payload_length, want.packet_code,
                       got.status, got.payload_length, got.packet_code);
            fail_count++;
          end
        end
      end
      if (frames.valid && frames.ready) begin
        if (parse_frame_byte(frames.frame_byte, frames.frame_start, want))
          expected_results.push_back(want);
        bytes_accepted <= bytes_accepted + 1;
      end
      if ((frames.valid && frames.ready) || (results.valid && results.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("serial_io_frame_checker test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [7:0]  len_byte;
    rst = 1'b1;

    // Bytes outside a frame, then bad start marks.
    push_byte(8'h55, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // Length byte of one, zero length, a frame with data.
    add_frame(8'h00, 8'd1, 1'b1, -1);
    add_frame(8'hFF, 8'd0, 1'b1, -1);
    add_frame(8'hFF, 8'd3, 1'b1, -1);
    // Restart inside a frame, once with a bad mark and once with a good one.
    add_frame(8'h12, 8'd5, 1'b1, 3);
    push_byte(8'hE1, 1'b1);
    add_frame(8'h34, 8'd2, 1'b1, 1);
    add_frame(8'h80, 8'd1, 1'b0, -1);

    // One frame of the largest length, then mostly well-formed frames.
    add_frame(8'($urandom_range(0, 255)), 8'hFF, 1'b1, -1);
    while (byte_queue.size() < STIM_BYTES) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 199) == 0) begin
        len_byte = 8'hFF;
      end else if ($urandom_range(0, 19) == 0) begin
        len_byte = 8'($urandom_range(1, 254));
      end else begin
        len_byte = 8'($urandom_range(1, 8));
      end
      if (pick < 75) begin
        add_frame(8'($urandom_range(0, 255)), len_byte, $urandom_range(0, 3) != 0, -1);
      end else if (pick < 83) begin
        add_frame(8'($urandom_range(0, 255)), len_byte, 1'b1,
                  $urandom_range(1, int'(len_byte) + 2));
      end else if (pick < 88) begin
        add_frame(8'($urandom_range(0, 255)), 8'd0, 1'b1, -1);
      end else if (pick < 94) begin
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || frames.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("serial_io_frame_checker test passed");
    end else begin
      $display("serial_io_frame_checker test failed");
    end
    $finish;
  end

endmodule
